// File: sv/jog_pkg.sv
// Shared constants, register codes and the beat type for the Julia orbit generator.
// Used by jog_cell and julia_orbit_generator; depends on nothing else.
`default_nettype none

package jog_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 28;
    localparam int MAX_ORBIT = 64;
    localparam int DIGIT_W   = 8;
    localparam int N_CELLS   = WORD_W / DIGIT_W;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int IN_W      = 31;
    localparam int K_W       = 30;
    localparam int ITER_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = $clog2(MAX_ORBIT + 1);
    localparam int SUM_W     = PROD_W + 1;

    localparam int  ESC_SHIFT = 2 * FRAC_BITS + 2;
    localparam bit  ESC_ON    = (ESC_SHIFT < PROD_W);
    localparam logic [SUM_W-1:0] ESC_LIMIT =
        ESC_ON ? (SUM_W'(1) << ESC_SHIFT) : '0;

    localparam logic [CFG_IDX_W-1:0] CFG_K_REAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_K_IMAG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd2;

    localparam logic signed [K_W-1:0] K_REAL_RST   = -30'sd202587165;
    localparam logic signed [K_W-1:0] K_IMAG_RST   = -30'sd14072219;
    localparam logic [ITER_W-1:0]     MAX_ITER_RST = ITER_W'(MAX_ORBIT);

    // Operands and partial sums handed from one multiplier cell to the next.
    typedef struct packed {
        logic [PROD_W-1:0] ma_re;
        logic [PROD_W-1:0] ma_im;
        logic [WORD_W-1:0] mb_re;
        logic [WORD_W-1:0] mb_im;
        logic [PROD_W-1:0] acc_rr;
        logic [PROD_W-1:0] acc_ii;
        logic [PROD_W-1:0] acc_ri;
        logic              neg_ri;
    } jog_beat_t;

endpackage

`default_nettype wire

// File: sv/jog_cell.sv
// One cell of the digit multiplier chain: adds one multiplier digit's partial products.
// Depends on jog_pkg.
`default_nettype none

module jog_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid_in,
    input  wire jog_pkg::jog_beat_t beat_in,
    output logic                   valid_out,
    output jog_pkg::jog_beat_t     beat_out
);

    logic                          valid_reg;
    jog_pkg::jog_beat_t            beat_reg;
    jog_pkg::jog_beat_t            beat_next;
    logic [jog_pkg::DIGIT_W-1:0]   d_re;
    logic [jog_pkg::DIGIT_W-1:0]   d_im;
    logic [jog_pkg::PROD_W-1:0]    pp_rr;
    logic [jog_pkg::PROD_W-1:0]    pp_ii;
    logic [jog_pkg::PROD_W-1:0]    pp_ri;

    // The multiplier words shift down and the multiplicands shift up, so every
    // cell works on its own low digit without knowing its place in the row.
    always_comb
    begin
        d_re  = beat_in.mb_re[jog_pkg::DIGIT_W-1:0];
        d_im  = beat_in.mb_im[jog_pkg::DIGIT_W-1:0];
        pp_rr = beat_in.ma_re * jog_pkg::PROD_W'(d_re);
        pp_ii = beat_in.ma_im * jog_pkg::PROD_W'(d_im);
        pp_ri = beat_in.ma_re * jog_pkg::PROD_W'(d_im);

        beat_next        = beat_in;
        beat_next.ma_re  = beat_in.ma_re << jog_pkg::DIGIT_W;
        beat_next.ma_im  = beat_in.ma_im << jog_pkg::DIGIT_W;
        beat_next.mb_re  = beat_in.mb_re >> jog_pkg::DIGIT_W;
        beat_next.mb_im  = beat_in.mb_im >> jog_pkg::DIGIT_W;
        beat_next.acc_rr = beat_in.acc_rr + pp_rr;
        beat_next.acc_ii = beat_in.acc_ii + pp_ii;
        beat_next.acc_ri = beat_in.acc_ri + pp_ri;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign valid_out = valid_reg;
    assign beat_out  = beat_reg;

endmodule

`default_nettype wire

// File: sv/julia_orbit_generator.sv
// Top level of the Julia orbit generator: control, configuration registers and update stage.
// Depends on jog_pkg and jog_cell.
//
//   channel   ports                                    handshake
//   input     start_re, start_im                       start, busy
//   result    point_re, point_im, last_point, escaped  point_valid (one-cycle strobe)
//   config    cfg_addr, cfg_data                       cfg_we
//
// Every orbit point passes through the row of multiplier cells, which forms the two
// squares and the cross product one byte of the multiplier at a time, then a register
// stage that combines them and tests the escape bound, then the stage that adds k and
// emits. busy falls with the last strobe, so the next start is taken in that cycle.
// Reset restores the constant and the iteration limit; results cannot be stalled.
`default_nettype none

module julia_orbit_generator (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [jog_pkg::IN_W-1:0]      start_re,
    input  wire logic signed [jog_pkg::IN_W-1:0]      start_im,
    input  wire logic                                 cfg_we,
    input  wire logic [jog_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  wire logic [jog_pkg::K_W-1:0]              cfg_data,
    output logic                                      point_valid,
    output logic signed [jog_pkg::WORD_W-1:0]         point_re,
    output logic signed [jog_pkg::WORD_W-1:0]         point_im,
    output logic                                      last_point,
    output logic                                      escaped
);

    localparam int SH_W = jog_pkg::SUM_W;

    logic signed [jog_pkg::K_W-1:0]     k_real_reg;
    logic signed [jog_pkg::K_W-1:0]     k_imag_reg;
    logic [jog_pkg::ITER_W-1:0]         max_iter_reg;

    logic                               busy_reg;
    logic                               launch_reg;
    logic [jog_pkg::CNT_W-1:0]          n_reg;
    logic signed [jog_pkg::WORD_W-1:0]  z_re_reg;
    logic signed [jog_pkg::WORD_W-1:0]  z_im_reg;

    logic                               a_valid_reg;
    logic                               a_esc_reg;
    logic signed [SH_W-1:0]             a_sq_reg;
    logic signed [SH_W-1:0]             a_cr_reg;

    logic                               strobe_reg;
    logic signed [jog_pkg::WORD_W-1:0]  out_re_reg;
    logic signed [jog_pkg::WORD_W-1:0]  out_im_reg;
    logic                               out_last_reg;
    logic                               out_esc_reg;

    logic                               accept;
    logic [jog_pkg::ITER_W-1:0]         limit;
    logic                               is_last;
    logic [jog_pkg::WORD_W-1:0]         mag_re;
    logic [jog_pkg::WORD_W-1:0]         mag_im;
    logic [jog_pkg::N_CELLS:0]          chain_valid;
    jog_pkg::jog_beat_t                 chain_beat [jog_pkg::N_CELLS+1];
    jog_pkg::jog_beat_t                 tail;
    logic [SH_W-1:0]                    mag2;
    logic signed [SH_W-1:0]             sq_sh;
    logic signed [SH_W-1:0]             cr_sh;
    logic signed [SH_W-1:0]             nre_wide;
    logic signed [SH_W-1:0]             nim_wide;
    logic signed [jog_pkg::WORD_W-1:0]  nre_sat;
    logic signed [jog_pkg::WORD_W-1:0]  nim_sat;

    function automatic logic signed [jog_pkg::WORD_W-1:0] sat_word(
        input logic signed [SH_W-1:0] x
    );
        logic hi_ok;
        logic lo_ok;
        begin
            hi_ok = &(~x[SH_W-1:jog_pkg::WORD_W-1]);
            lo_ok = &x[SH_W-1:jog_pkg::WORD_W-1];
            if (hi_ok || lo_ok)
                sat_word = x[jog_pkg::WORD_W-1:0];
            else if (x[SH_W-1])
                sat_word = {1'b1, {(jog_pkg::WORD_W-1){1'b0}}};
            else
                sat_word = {1'b0, {(jog_pkg::WORD_W-1){1'b1}}};
        end
    endfunction

    assign accept = start && !busy_reg;

    always_comb
    begin
        if (max_iter_reg == '0)
            limit = jog_pkg::ITER_W'(1);
        else if (max_iter_reg > jog_pkg::ITER_W'(jog_pkg::MAX_ORBIT))
            limit = jog_pkg::ITER_W'(jog_pkg::MAX_ORBIT);
        else
            limit = max_iter_reg;
    end

    assign is_last = a_esc_reg ||
        (jog_pkg::ITER_W'(n_reg) + jog_pkg::ITER_W'(1) == limit);

    // Magnitudes feed the unsigned cells; the sign of the cross term rides along.
    always_comb
    begin
        mag_re = z_re_reg[jog_pkg::WORD_W-1] ? -z_re_reg : z_re_reg;
        mag_im = z_im_reg[jog_pkg::WORD_W-1] ? -z_im_reg : z_im_reg;
        chain_beat[0].ma_re  = jog_pkg::PROD_W'(mag_re);
        chain_beat[0].ma_im  = jog_pkg::PROD_W'(mag_im);
        chain_beat[0].mb_re  = mag_re;
        chain_beat[0].mb_im  = mag_im;
        chain_beat[0].acc_rr = '0;
        chain_beat[0].acc_ii = '0;
        chain_beat[0].acc_ri = '0;
        chain_beat[0].neg_ri = z_re_reg[jog_pkg::WORD_W-1] ^ z_im_reg[jog_pkg::WORD_W-1];
    end

    assign chain_valid[0] = launch_reg;

    for (genvar i = 0; i < jog_pkg::N_CELLS; i++)
    begin : g_cell
        jog_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (chain_valid[i]),
            .beat_in   (chain_beat[i]),
            .valid_out (chain_valid[i+1]),
            .beat_out  (chain_beat[i+1])
        );
    end

    assign tail = chain_beat[jog_pkg::N_CELLS];
    assign mag2 = SH_W'(tail.acc_rr) + SH_W'(tail.acc_ii);

    // Arithmetic shifts give the floor rounding; k is sign-extended before the add.
    always_comb
    begin
        sq_sh    = a_sq_reg >>> jog_pkg::FRAC_BITS;
        cr_sh    = a_cr_reg >>> (jog_pkg::FRAC_BITS - 1);
        nre_wide = sq_sh + SH_W'(k_real_reg);
        nim_wide = cr_sh + SH_W'(k_imag_reg);
        nre_sat  = sat_word(nre_wide);
        nim_sat  = sat_word(nim_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_real_reg   <= jog_pkg::K_REAL_RST;
            k_imag_reg   <= jog_pkg::K_IMAG_RST;
            max_iter_reg <= jog_pkg::MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                jog_pkg::CFG_K_REAL:   k_real_reg   <= cfg_data;
                jog_pkg::CFG_K_IMAG:   k_imag_reg   <= cfg_data;
                jog_pkg::CFG_MAX_ITER: max_iter_reg <= cfg_data[jog_pkg::ITER_W-1:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            launch_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            launch_reg  <= 1'b0;
            strobe_reg  <= 1'b0;
            a_valid_reg <= chain_valid[jog_pkg::N_CELLS];
            if (accept)
            begin
                busy_reg   <= 1'b1;
                launch_reg <= 1'b1;
            end
            else if (a_valid_reg)
            begin
                strobe_reg <= 1'b1;
                if (is_last)
                    busy_reg <= 1'b0;
                else
                    launch_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_esc_reg <= jog_pkg::ESC_ON && (mag2 > jog_pkg::ESC_LIMIT);
        a_sq_reg  <= $signed(SH_W'(tail.acc_rr)) - $signed(SH_W'(tail.acc_ii));
        a_cr_reg  <= tail.neg_ri ? -$signed(SH_W'(tail.acc_ri))
                                 :  $signed(SH_W'(tail.acc_ri));
        if (accept)
        begin
            z_re_reg <= {start_re[jog_pkg::IN_W-1], start_re};
            z_im_reg <= {start_im[jog_pkg::IN_W-1], start_im};
            n_reg    <= '0;
        end
        else if (a_valid_reg)
        begin
            out_re_reg   <= z_re_reg;
            out_im_reg   <= z_im_reg;
            out_last_reg <= is_last;
            out_esc_reg  <= a_esc_reg;
            if (!is_last)
            begin
                z_re_reg <= nre_sat;
                z_im_reg <= nim_sat;
                n_reg    <= n_reg + jog_pkg::CNT_W'(1);
            end
        end
    end

    assign busy        = busy_reg;
    assign point_valid = strobe_reg;
    assign point_re    = out_re_reg;
    assign point_im    = out_im_reg;
    assign last_point  = out_last_reg;
    assign escaped     = out_esc_reg;

endmodule

`default_nettype wire

// File: test/julia_orbit_generator_tb.sv
// Self-checking testbench for julia_orbit_generator: predicts every orbit point of each
// accepted start point in fixed point and compares the result beats field by field.
// Depends on jog_pkg and the julia_orbit_generator RTL.

module julia_orbit_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Index past the last register; writes to it must leave every register alone.
    localparam logic [jog_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam longint unsigned ESC_BOUND    = 64'd1 << (2 * jog_pkg::FRAC_BITS + 2);
    localparam int              DRAIN_CYCLES = 16;
    localparam int              RANDOM_ITEMS = 188;
    localparam int              PHASE_ITEMS  = 20;

    localparam logic signed [jog_pkg::IN_W-1:0] IN_TOP    =
        {1'b0, {(jog_pkg::IN_W-1){1'b1}}};
    localparam logic signed [jog_pkg::IN_W-1:0] IN_BOTTOM =
        {1'b1, {(jog_pkg::IN_W-1){1'b0}}};
    localparam logic signed [jog_pkg::IN_W-1:0] RADIUS    =
        jog_pkg::IN_W'(2) << jog_pkg::FRAC_BITS;
    localparam logic [jog_pkg::K_W-1:0]         K_TOP     = {1'b0, {(jog_pkg::K_W-1){1'b1}}};
    localparam logic [jog_pkg::K_W-1:0]         K_BOTTOM  = {1'b1, {(jog_pkg::K_W-1){1'b0}}};

    typedef struct {
        logic signed [jog_pkg::WORD_W-1:0] re;
        logic signed [jog_pkg::WORD_W-1:0] im;
        logic                              last;
        logic                              esc;
    } orbit_point_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic signed [jog_pkg::IN_W-1:0]     start_re;
    logic signed [jog_pkg::IN_W-1:0]     start_im;
    logic                                cfg_we;
    logic [jog_pkg::CFG_IDX_W-1:0]       cfg_addr;
    logic [jog_pkg::K_W-1:0]             cfg_data;
    logic                                point_valid;
    logic signed [jog_pkg::WORD_W-1:0]   point_re;
    logic signed [jog_pkg::WORD_W-1:0]   point_im;
    logic                                last_point;
    logic                                escaped;

    // Shadow copy of the configuration registers.
    longint                              k_re_m = jog_pkg::K_REAL_RST;
    longint                              k_im_m = jog_pkg::K_IMAG_RST;
    logic [jog_pkg::ITER_W-1:0]          iter_m = jog_pkg::MAX_ITER_RST;

    orbit_point_t               pending_points[$];
    bit                         no_idle = 1'b0;
    int                         failures = 0;
    int                         items_sent = 0;
    int                         points_checked = 0;
    int                         escapes_seen = 0;
    int                         reg_writes = 0;

    julia_orbit_generator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .start_re    (start_re),
        .start_im    (start_im),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .point_valid (point_valid),
        .point_re    (point_re),
        .point_im    (point_im),
        .last_point  (last_point),
        .escaped     (escaped)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint clamp_word(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic bit beyond_radius(input longint re, input longint im);
        longint unsigned a;
        longint unsigned b;
        a = (re < 0) ? -re : re;
        b = (im < 0) ? -im : im;
        return (a * a + b * b) > ESC_BOUND;
    endfunction

    // Walks the orbit of one start point and queues every point the block should emit.
    function automatic void trace_orbit(input logic signed [jog_pkg::IN_W-1:0] sre,
                                        input logic signed [jog_pkg::IN_W-1:0] sim);
        longint       re;
        longint       im;
        longint       sq;
        longint       cr;
        int           limit;
        int           n;
        bit           esc;
        bit           fin;
        orbit_point_t p;
        re = sre;
        im = sim;
        limit = iter_m;
        if (limit < 1)
            limit = 1;
        if (limit > jog_pkg::MAX_ORBIT)
            limit = jog_pkg::MAX_ORBIT;
        for (n = 0; n < limit; n++)
        begin
            esc = beyond_radius(re, im);
            fin = esc || (n + 1 == limit);
            p.re = re[jog_pkg::WORD_W-1:0];
            p.im = im[jog_pkg::WORD_W-1:0];
            p.last = fin;
            p.esc = esc;
            pending_points.insert(pending_points.size(), p);
            if (fin)
                break;
            sq = re * re - im * im;
            cr = re * im;
            re = clamp_word((sq >>> jog_pkg::FRAC_BITS) + k_re_m);
            im = clamp_word((cr >>> (jog_pkg::FRAC_BITS - 1)) + k_im_m);
        end
    endfunction

    function automatic int rand_span(input int unsigned r);
        return int'($urandom_range(0, 2 * r)) - int'(r);
    endfunction

    // Sends one start point; returns at the edge that accepts the beat.
    task automatic launch_orbit(input logic signed [jog_pkg::IN_W-1:0] re_v,
                                input logic signed [jog_pkg::IN_W-1:0] im_v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        start_re <= re_v;
        start_im <= im_v;
        do
            @(posedge clk);
        while (busy);
        trace_orbit(re_v, im_v);
        items_sent++;
    endtask

    task automatic launch_random_orbit();
        logic signed [jog_pkg::IN_W-1:0] re_v;
        logic signed [jog_pkg::IN_W-1:0] im_v;
        case ($urandom_range(0, 9)) inside
            [0:5]:
            begin
                re_v = jog_pkg::IN_W'(rand_span(32'd1 << 29));
                im_v = jog_pkg::IN_W'(rand_span(32'd1 << 29));
            end
            [6:7]:
            begin
                re_v = jog_pkg::IN_W'(rand_span((32'd1 << 29) + (32'd1 << 26)));
                im_v = jog_pkg::IN_W'(rand_span(32'd1 << 27));
                if ($urandom_range(0, 1))
                begin
                    re_v = im_v;
                    im_v = jog_pkg::IN_W'(rand_span((32'd1 << 29) + (32'd1 << 26)));
                end
            end
            default:
            begin
                re_v = jog_pkg::IN_W'($urandom);
                im_v = jog_pkg::IN_W'($urandom);
            end
        endcase
        launch_orbit(re_v, im_v);
    endtask

    // Holds the sender off until every queued point has arrived and the block is quiet.
    task automatic quiesce();
        @(negedge clk);
        start <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [jog_pkg::CFG_IDX_W-1:0] idx,
                             input logic [jog_pkg::K_W-1:0] data);
        @(negedge clk);
        start    <= 1'b0;
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            jog_pkg::CFG_K_REAL:   k_re_m = signed'(data);
            jog_pkg::CFG_K_IMAG:   k_im_m = signed'(data);
            jog_pkg::CFG_MAX_ITER: iter_m = data[jog_pkg::ITER_W-1:0];
            default:               ;
        endcase
        reg_writes++;
    endtask

    always @(posedge clk)
    begin
        orbit_point_t want;
        if (rst_n && point_valid)
        begin
            if (pending_points.size() == 0)
            begin
                $error("result beat with nothing expected: point_re=%0d point_im=%0d",
                       point_re, point_im);
                failures++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (point_re !== want.re)
                begin
                    $error("point_re: expected %0d, got %0d", want.re, point_re);
                    failures++;
                end
                if (point_im !== want.im)
                begin
                    $error("point_im: expected %0d, got %0d", want.im, point_im);
                    failures++;
                end
                if (last_point !== want.last)
                begin
                    $error("last_point: expected %0b, got %0b", want.last, last_point);
                    failures++;
                end
                if (escaped !== want.esc)
                begin
                    $error("escaped: expected %0b, got %0b", want.esc, escaped);
                    failures++;
                end
                points_checked++;
                if (want.esc)
                    escapes_seen++;
            end
        end
    end

    // Reset values of the constant and limit, extremes of the start point, the radius edge.
    task automatic test_reset_values();
        launch_orbit('0, '0);
        launch_orbit(IN_TOP, IN_TOP);
        launch_orbit(IN_BOTTOM, IN_BOTTOM);
        launch_orbit(RADIUS, '0);
        launch_orbit(RADIUS + jog_pkg::IN_W'(1), '0);
        launch_orbit(IN_BOTTOM, IN_TOP);
        // The sender waits for a full drain before the next beat.
        quiesce();
        launch_orbit(jog_pkg::IN_W'(1) << (jog_pkg::FRAC_BITS - 1),
                     -(jog_pkg::IN_W'(1) << (jog_pkg::FRAC_BITS - 2)));
    endtask

    // Iteration limit of one, zero (taken as one), above the orbit size, and two.
    task automatic test_iter_limits();
        int unsigned limits[5];
        int          i;
        limits = '{1, 0, 127, 65, 2};
        for (i = 0; i < 5; i++)
        begin
            quiesce();
            write_reg(jog_pkg::CFG_MAX_ITER,
                      {(jog_pkg::K_W - jog_pkg::ITER_W)'(
                           $urandom_range(0, (1 << (jog_pkg::K_W - jog_pkg::ITER_W)) - 1)),
                       jog_pkg::ITER_W'(limits[i])});
            launch_orbit(jog_pkg::IN_W'(rand_span(32'd1 << 28)),
                         jog_pkg::IN_W'(rand_span(32'd1 << 28)));
        end
        launch_orbit(IN_BOTTOM, '0);
    endtask

    // Constant at its extremes and at zero, and a write to the unused index that must change nothing.
    task automatic test_constant_extremes();
        logic [jog_pkg::K_W-1:0] kr[4];
        logic [jog_pkg::K_W-1:0] ki[4];
        int                      i;
        kr = '{K_TOP, K_BOTTOM, K_TOP, '0};
        ki = '{K_TOP, K_BOTTOM, K_BOTTOM, '0};
        quiesce();
        write_reg(jog_pkg::CFG_MAX_ITER, jog_pkg::K_W'(jog_pkg::MAX_ORBIT));
        for (i = 0; i < 4; i++)
        begin
            quiesce();
            write_reg(jog_pkg::CFG_K_REAL, kr[i]);
            write_reg(jog_pkg::CFG_K_IMAG, ki[i]);
            launch_orbit('0, '0);
            launch_orbit(jog_pkg::IN_W'(rand_span(32'd1 << 28)),
                         jog_pkg::IN_W'(rand_span(32'd1 << 28)));
        end
        quiesce();
        write_reg(CFG_SPARE, jog_pkg::K_W'($urandom));
        launch_orbit(jog_pkg::IN_W'(rand_span(32'd1 << 28)),
                     jog_pkg::IN_W'(rand_span(32'd1 << 28)));
    endtask

    task automatic test_random_orbits(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if (i % PHASE_ITEMS == 0)
            begin
                quiesce();
                no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) == 0)
                begin
                    write_reg(jog_pkg::CFG_K_REAL, jog_pkg::K_W'($urandom));
                    write_reg(jog_pkg::CFG_K_IMAG, jog_pkg::K_W'($urandom));
                end
                else
                begin
                    write_reg(jog_pkg::CFG_K_REAL,
                              jog_pkg::K_W'(rand_span(32'd1 << jog_pkg::FRAC_BITS)));
                    write_reg(jog_pkg::CFG_K_IMAG,
                              jog_pkg::K_W'(rand_span(32'd1 << jog_pkg::FRAC_BITS)));
                end
                case ($urandom_range(0, 9)) inside
                    [0:4]:
                        write_reg(jog_pkg::CFG_MAX_ITER,
                                  jog_pkg::K_W'($urandom_range(1, 16)));
                    [5:7]:
                        write_reg(jog_pkg::CFG_MAX_ITER,
                                  jog_pkg::K_W'($urandom_range(17, jog_pkg::MAX_ORBIT)));
                    default:
                        write_reg(jog_pkg::CFG_MAX_ITER, jog_pkg::K_W'($urandom));
                endcase
                if ($urandom_range(0, 5) == 0)
                    write_reg(CFG_SPARE, jog_pkg::K_W'($urandom));
            end
            launch_random_orbit();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        start_re = '0;
        start_im = '0;
        cfg_we   = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_iter_limits();
        test_constant_extremes();
        test_random_orbits(RANDOM_ITEMS);
        quiesce();

        $display("Run covered %0d start points and %0d orbit points, %0d of them escaping,",
                 items_sent, points_checked, escapes_seen);
        $display("across %0d register writes including limit and constant extremes.",
                 reg_writes);
        if (failures == 0)
            $display("julia_orbit_generator_tb passed");
        else
            $display("julia_orbit_generator_tb failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("julia_orbit_generator_tb failed");
        $finish;
    end

endmodule
